/* hw/rtl/qrs_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, constants and types of the quadratic root solver.
// No dependencies; used by qrs_sqrt, qrs_div and quadratic_root_solver.
package qrs_pkg;

  localparam int COEF_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int OUT_BITS  = 48;
  localparam int THR_BITS  = 16;

  localparam int MAG_W  = COEF_BITS;
  localparam int PROD_W = 2 * MAG_W;
  localparam int RAD_W  = 2 * MAG_W + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int SR_W   = ROOT_W + 4;
  localparam int QM_W   = ROOT_W + 1;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int QQ_W   = 2 * QM_W;
  localparam int CS_W   = MAG_W + ROOT_W;
  localparam int DEN_W  = 2 * ROOT_W + 1;
  localparam int NUM_W  = MAG_W + ROOT_W + FRAC_BITS + 1;
  localparam int HI_W   = NUM_W - OUT_BITS;
  localparam int RW     = DEN_W + 1;
  localparam int TT_W   = 2 * THR_BITS;
  localparam int BIGT_W = TT_W + 2;

  localparam int SQ_LAT  = ROOT_W + 1;
  localparam int DIV_LAT = OUT_BITS + 1;
  localparam int NUM_DIV = 4;

  typedef struct packed {
    logic [MAG_W-1:0]  am;
    logic [MAG_W-1:0]  bm;
    logic [MAG_W-1:0]  cm;
    logic              an;
    logic              bn;
    logic              cn;
    logic              azero;
    logic              bzero;
    logic              cplx;
    logic [TT_W-1:0]   tt;
    logic [PROD_W-1:0] b2;
  } side_t;

  typedef struct packed {
    logic             neg;
    logic             en;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                sat;
    logic [OUT_BITS-1:0] val;
  } div_res_t;

endpackage

/* hw/rtl/qrs_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined integer square root, two radicand bits per stage, rounded to nearest.
// Depends on qrs_pkg. One item per cycle.
module qrs_sqrt (
  input  logic                       clk,
  input  logic [qrs_pkg::RAD_W-1:0]  rad,
  output logic [qrs_pkg::ROOT_W-1:0] root
);
  import qrs_pkg::*;

  logic [SR_W-1:0]   rm [1:ROOT_W];
  logic [ROOT_W-1:0] qv [1:ROOT_W];
  logic [RAD_W-1:0]  nv [1:ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [SR_W-1:0]   rp;
    logic [ROOT_W-1:0] qp;
    logic [RAD_W-1:0]  np;
    logic [SR_W-1:0]   qx;
    logic [SR_W-1:0]   rr;
    logic [SR_W-1:0]   tr;
    if (k == 0) begin : g_first
      assign rp = '0;
      assign qp = '0;
      assign np = rad;
    end else begin : g_next
      assign rp = rm[k];
      assign qp = qv[k];
      assign np = nv[k];
    end
    assign qx = SR_W'(qp);
    assign rr = {rp[SR_W-3:0], np[RAD_W-1:RAD_W-2]};
    assign tr = {qx[SR_W-3:0], 2'b01};
    always_ff @(posedge clk) begin
      if (rr >= tr) begin
        rm[k+1] <= rr - tr;
        qv[k+1] <= {qp[ROOT_W-2:0], 1'b1};
      end else begin
        rm[k+1] <= rr;
        qv[k+1] <= {qp[ROOT_W-2:0], 1'b0};
      end
      nv[k+1] <= {np[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    root <= qv[ROOT_W] + ROOT_W'(rm[ROOT_W] > SR_W'(qv[ROOT_W]));
  end

endmodule

/* hw/rtl/qrs_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with rounding,
// sign and saturation to the output range. Depends on qrs_pkg.
module qrs_div (
  input  logic              clk,
  input  qrs_pkg::div_req_t req,
  output qrs_pkg::div_res_t res
);
  import qrs_pkg::*;

  localparam int L = OUT_BITS;

  logic [RW-1:0]    r  [0:L];
  logic [L-1:0]     nl [0:L];
  logic [L-1:0]     q  [0:L];
  logic [DEN_W-1:0] d  [0:L];
  logic             ng [0:L];
  logic             en [0:L];
  logic             ov [0:L];

  always_ff @(posedge clk) begin
    r[0]  <= RW'(req.num[NUM_W-1:L]);
    nl[0] <= req.num[L-1:0];
    q[0]  <= '0;
    d[0]  <= req.den;
    ng[0] <= req.neg;
    en[0] <= req.en;
    ov[0] <= DEN_W'(req.num[NUM_W-1:L]) >= req.den;
  end

  for (genvar k = 0; k < L; k++) begin : g_step
    logic [RW-1:0] rr;
    assign rr = {r[k][RW-2:0], nl[k][L-1]};
    always_ff @(posedge clk) begin
      if (rr >= RW'(d[k])) begin
        r[k+1] <= rr - RW'(d[k]);
        q[k+1] <= {q[k][L-2:0], 1'b1};
      end else begin
        r[k+1] <= rr;
        q[k+1] <= {q[k][L-2:0], 1'b0};
      end
      nl[k+1] <= {nl[k][L-2:0], 1'b0};
      d[k+1]  <= d[k];
      ng[k+1] <= ng[k];
      en[k+1] <= en[k];
      ov[k+1] <= ov[k];
    end
  end

  logic       up;
  logic       big;
  logic [L:0] qr;
  logic [L:0] lim;
  logic [L:0] mag;
  logic [L:0] negm;

  always_comb begin
    up   = {r[L], 1'b0} >= (RW+1)'(d[L]);
    qr   = {1'b0, q[L]} + (L+1)'(up);
    lim  = {2'b01, {(L-1){1'b0}}} - (L+1)'(!ng[L]);
    big  = ov[L] || (qr > lim);
    mag  = big ? lim : qr;
    negm = ~mag + 1'b1;
    res.sat = en[L] && big;
    if (!en[L]) begin
      res.val = '0;
    end else if (ng[L]) begin
      res.val = negm[L-1:0];
    end else begin
      res.val = mag[L-1:0];
    end
  end

endmodule

/* hw/rtl/quadratic_root_solver.sv */
`timescale 1ns / 1ps
// Quadratic root solver: up to two roots of a*x^2+b*x+c, real or a complex pair.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
//
// Usage:
//   Drive coef_a, coef_b, coef_c (signed Q16.16) and raise start; the item is
//   taken at any rising edge with start high and busy low. busy stays low, so
//   a new item can enter every cycle.
//   Each result shows on the output ports for one cycle with done high:
//   first/second root (Q32.16), root_count, is_complex and saturated.
//   Pipeline: an accepted item passes 3 front stages, SQ_LAT = 34 square-root
//   stages, 2 product stages, DIV_LAT = 49 divider stages and 1 output stage
//   before done rises. Throughput: one item per cycle, set by the
//   bit-per-stage square root and the four dividers.
//   Configuration: zero_threshold is written through cfg_valid/cfg_data;
//   cfg_ready is always high. Write it only while no item is in flight.
//   Reset: rst (synchronous) clears all valid bits and sets the threshold to 1.
//   The receiver cannot stall; results are never held.
module quadratic_root_solver (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [qrs_pkg::COEF_BITS-1:0] coef_a,
  input  logic signed [qrs_pkg::COEF_BITS-1:0] coef_b,
  input  logic signed [qrs_pkg::COEF_BITS-1:0] coef_c,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qrs_pkg::THR_BITS-1:0]        cfg_data,
  output logic                                done,
  output logic signed [qrs_pkg::OUT_BITS-1:0] first_re,
  output logic signed [qrs_pkg::OUT_BITS-1:0] first_im,
  output logic signed [qrs_pkg::OUT_BITS-1:0] second_re,
  output logic signed [qrs_pkg::OUT_BITS-1:0] second_im,
  output logic [1:0]                          root_count,
  output logic                                is_complex,
  output logic                                saturated
);
  import qrs_pkg::*;

  function automatic logic [MAG_W-1:0] coef_mag(input logic [COEF_BITS-1:0] x);
    return x[COEF_BITS-1] ? (~x + 1'b1) : x;
  endfunction

  logic [THR_BITS-1:0] zero_threshold;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_threshold <= THR_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      zero_threshold <= cfg_data;
    end
  end

  // front stages
  logic                v0;
  logic [MAG_W-1:0]    am0, bm0, cm0;
  logic                an0, bn0, cn0;
  logic [THR_BITS-1:0] t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    am0 <= coef_mag(coef_a);
    bm0 <= coef_mag(coef_b);
    cm0 <= coef_mag(coef_c);
    an0 <= coef_a[COEF_BITS-1];
    bn0 <= coef_b[COEF_BITS-1];
    cn0 <= coef_c[COEF_BITS-1];
    t0  <= zero_threshold;
  end

  logic              v1;
  side_t             side1;
  logic [PROD_W-1:0] ac1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    side1.am    <= am0;
    side1.bm    <= bm0;
    side1.cm    <= cm0;
    side1.an    <= an0;
    side1.bn    <= bn0;
    side1.cn    <= cn0;
    side1.azero <= (am0 < MAG_W'(t0)) || (am0 == '0);
    side1.bzero <= (bm0 < MAG_W'(t0)) || (bm0 == '0);
    side1.cplx  <= 1'b0;
    side1.tt    <= t0 * t0;
    side1.b2    <= bm0 * bm0;
    ac1         <= am0 * cm0;
  end

  logic [RAD_W-1:0] ac4, b2e, rad_next, rad2;
  logic             cplx_next;
  side_t            side2_next;

  always_comb begin
    ac4 = {ac1, 2'b00};
    b2e = RAD_W'(side1.b2);
    cplx_next = 1'b0;
    if (side1.an != side1.cn) begin
      rad_next = b2e + ac4;
    end else if (b2e >= ac4) begin
      rad_next = b2e - ac4;
    end else begin
      rad_next  = ac4 - b2e;
      cplx_next = 1'b1;
    end
    side2_next      = side1;
    side2_next.cplx = cplx_next;
  end

  // square root with side data held alongside
  side_t             sd [0:SQ_LAT];
  logic [SQ_LAT:0]   vd;
  logic [ROOT_W-1:0] s_root;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else begin
      vd <= {vd[SQ_LAT-1:0], v1};
    end
  end

  always_ff @(posedge clk) begin
    rad2  <= rad_next;
    sd[0] <= side2_next;
  end

  for (genvar k = 0; k < SQ_LAT; k++) begin : g_side
    always_ff @(posedge clk) begin
      sd[k+1] <= sd[k];
    end
  end

  qrs_sqrt u_sqrt (
    .clk  (clk),
    .rad  (rad2),
    .root (s_root)
  );

  // products
  logic              v3, v4;
  side_t             side3, side4;
  logic [ROOT_W-1:0] s3, s4;
  logic [QM_W-1:0]   qm3, qm4;
  logic [PROD_W-1:0] cb3, cb4;
  logic [SQ_W-1:0]   ss3;
  logic [CS_W-1:0]   cs3, cs4;
  logic [DEN_W-1:0]  m4;
  logic [QQ_W-1:0]   qq4;
  logic [BIGT_W-1:0] bigt4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v3 <= vd[SQ_LAT];
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    side3 <= sd[SQ_LAT];
    s3    <= s_root;
    qm3   <= QM_W'(sd[SQ_LAT].bm) + QM_W'(s_root);
    cb3   <= sd[SQ_LAT].cm * sd[SQ_LAT].bm;
    ss3   <= s_root * s_root;
    cs3   <= sd[SQ_LAT].cm * s_root;
    side4 <= side3;
    s4    <= s3;
    qm4   <= qm3;
    cb4   <= cb3;
    cs4   <= cs3;
    m4    <= DEN_W'(side3.b2) + DEN_W'(ss3);
    qq4   <= qm3 * qm3;
    bigt4 <= {side3.tt, 2'b00};
  end

  // case selection and divider requests
  div_req_t         req [NUM_DIV];
  div_res_t         dres [NUM_DIV];
  logic [1:0]       cnt_next;
  logic             cplx_out;
  logic [DEN_W-1:0] twoa;
  logic             msmall, qsmall;

  always_comb begin
    for (int i = 0; i < NUM_DIV; i++) begin
      req[i] = '0;
    end
    cnt_next = 2'd0;
    cplx_out = 1'b0;
    twoa   = DEN_W'({side4.am, 1'b0});
    msmall = (m4 < DEN_W'(bigt4)) || (m4 == '0);
    qsmall = (qq4 < QQ_W'(bigt4)) || (qm4 == '0);
    if (side4.azero) begin
      if (!side4.bzero) begin
        req[0].en  = 1'b1;
        req[0].neg = side4.cn == side4.bn;
        req[0].num = NUM_W'(side4.cm) << FRAC_BITS;
        req[0].den = DEN_W'(side4.bm);
        cnt_next   = 2'd1;
      end
    end else if (side4.cplx) begin
      cplx_out   = 1'b1;
      req[0].en  = 1'b1;
      req[0].neg = side4.bn == side4.an;
      req[0].num = NUM_W'(side4.bm) << FRAC_BITS;
      req[0].den = twoa;
      req[1].en  = 1'b1;
      req[1].neg = (!side4.bn) != side4.an;
      req[1].num = NUM_W'(s4) << FRAC_BITS;
      req[1].den = twoa;
      if (msmall) begin
        cnt_next = 2'd1;
      end else begin
        req[2].en  = 1'b1;
        req[2].neg = side4.cn == side4.bn;
        req[2].num = NUM_W'(cb4) << (FRAC_BITS + 1);
        req[2].den = m4;
        req[3].en  = 1'b1;
        req[3].neg = side4.cn != side4.bn;
        req[3].num = NUM_W'(cs4) << (FRAC_BITS + 1);
        req[3].den = m4;
        cnt_next   = 2'd2;
      end
    end else begin
      req[0].en  = 1'b1;
      req[0].neg = (!side4.bn) != side4.an;
      req[0].num = NUM_W'(qm4) << FRAC_BITS;
      req[0].den = twoa;
      if (qsmall) begin
        cnt_next = 2'd1;
      end else begin
        req[2].en  = 1'b1;
        req[2].neg = side4.cn != (!side4.bn);
        req[2].num = NUM_W'(side4.cm) << (FRAC_BITS + 1);
        req[2].den = DEN_W'(qm4);
        cnt_next   = 2'd2;
      end
    end
  end

  for (genvar i = 0; i < NUM_DIV; i++) begin : g_div
    qrs_div u_div (
      .clk (clk),
      .req (req[i]),
      .res (dres[i])
    );
  end

  logic [DIV_LAT-1:0] mv;
  logic [1:0]         mcnt  [0:DIV_LAT-1];
  logic               mcplx [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= '0;
    end else begin
      mv <= {mv[DIV_LAT-2:0], v4};
    end
  end

  always_ff @(posedge clk) begin
    mcnt[0]  <= cnt_next;
    mcplx[0] <= cplx_out;
  end

  for (genvar k = 0; k < DIV_LAT - 1; k++) begin : g_meta
    always_ff @(posedge clk) begin
      mcnt[k+1]  <= mcnt[k];
      mcplx[k+1] <= mcplx[k];
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mv[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    first_re   <= dres[0].val;
    first_im   <= dres[1].val;
    second_re  <= dres[2].val;
    second_im  <= dres[3].val;
    root_count <= mcnt[DIV_LAT-1];
    is_complex <= mcplx[DIV_LAT-1];
    saturated  <= dres[0].sat || dres[1].sat || dres[2].sat || dres[3].sat;
  end

endmodule
